FILE: src/tcfp_pkg.sv
// Shared constants, codes and types of the tagged command frame parser.
`default_nettype none
package tcfp_pkg;

  localparam int unsigned STRING_LIMIT    = 4096;
  localparam int unsigned PARAMETER_LIMIT = 32;

  localparam int unsigned LEN_W   = 13;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 13;
  localparam int unsigned PH_W    = 3;

  localparam logic [LEN_W-1:0] STR_LIMIT_C = LEN_W'(STRING_LIMIT);
  localparam logic [CNT_W-1:0] PAR_LIMIT_C = CNT_W'(PARAMETER_LIMIT);

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_MAX_STRING = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_MAX_PARAM  = 2'd1;

  // parse phases
  localparam logic [PH_W-1:0] PH_NAME_LEN = 3'd0;
  localparam logic [PH_W-1:0] PH_NAME     = 3'd1;
  localparam logic [PH_W-1:0] PH_COUNT    = 3'd2;
  localparam logic [PH_W-1:0] PH_TYPE     = 3'd3;
  localparam logic [PH_W-1:0] PH_VALUE    = 3'd4;
  localparam logic [PH_W-1:0] PH_STRING   = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] EV_NAME_BYTE = 3'd0;
  localparam logic [KIND_W-1:0] EV_COUNT     = 3'd1;
  localparam logic [KIND_W-1:0] EV_HEAD      = 3'd2;
  localparam logic [KIND_W-1:0] EV_STR_BYTE  = 3'd3;
  localparam logic [KIND_W-1:0] EV_ERROR     = 3'd4;

  // error codes
  localparam logic ERR_LENGTH = 1'b0;
  localparam logic ERR_COUNT  = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] str_cap;
    logic [CNT_W-1:0] cnt_cap;
  } caps_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [7:0]        payload_byte;
    logic [IDX_W-1:0]  parameter_index;
    logic              parameter_is_string;
    logic [WORD_W-1:0] parameter_value;
    logic [CNT_W-1:0]  parameter_total;
    logic              error_code;
    logic              string_end;
    logic              command_done;
  } result_t;

  typedef struct packed {
    logic load;
    logic has_result;
  } step_t;

endpackage
`default_nettype wire

FILE: src/tcfp_in_if.sv
// Input byte channel of the parser.
`default_nettype none
interface tcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       connection_start;

  modport source (output valid, output data_byte, output connection_start, input ready);
  modport sink   (input valid, input data_byte, input connection_start, output ready);
endinterface
`default_nettype wire

FILE: src/tcfp_out_if.sv
// Result channel of the parser.
`default_nettype none
interface tcfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [4:0]  parameter_index;
  logic        parameter_is_string;
  logic [31:0] parameter_value;
  logic [5:0]  parameter_total;
  logic        error_code;
  logic        string_end;
  logic        command_done;

  modport source (
    output valid, output event_kind, output payload_byte, output parameter_index,
    output parameter_is_string, output parameter_value, output parameter_total,
    output error_code, output string_end, output command_done, input ready
  );
  modport sink (
    input valid, input event_kind, input payload_byte, input parameter_index,
    input parameter_is_string, input parameter_value, input parameter_total,
    input error_code, input string_end, input command_done, output ready
  );
endinterface
`default_nettype wire

FILE: src/tcfp_cfg_if.sv
// Configuration write channel of the parser.
`default_nettype none
interface tcfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/tcfp_cfg_regs.sv
// Configuration registers and effective limits of the parser.
`default_nettype none
module tcfp_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst_n,
  tcfp_cfg_if.sink     cfg_chan,
  output tcfp_pkg::caps_t caps
);
  import tcfp_pkg::*;

  logic [LEN_W-1:0] max_str_r;
  logic [CNT_W-1:0] max_par_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_str_r <= STR_LIMIT_C;
      max_par_r <= PAR_LIMIT_C;
    end else if (cfg_chan.valid) begin
      // unknown indexes are dropped
      if (cfg_chan.index == CFG_MAX_STRING) max_str_r <= cfg_chan.data[LEN_W-1:0];
      if (cfg_chan.index == CFG_MAX_PARAM)  max_par_r <= cfg_chan.data[CNT_W-1:0];
    end
  end

  assign caps.str_cap = (max_str_r < STR_LIMIT_C) ? max_str_r : STR_LIMIT_C;
  assign caps.cnt_cap = (max_par_r < PAR_LIMIT_C) ? max_par_r : PAR_LIMIT_C;

endmodule
`default_nettype wire

FILE: src/tcfp_parse_core.sv
// Input register, parse state and per-byte step logic.
`default_nettype none
module tcfp_parse_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tcfp_in_if.sink          in_chan,
  input  wire tcfp_pkg::caps_t caps,
  input  wire logic        out_stall,
  output tcfp_pkg::step_t  step,
  output tcfp_pkg::result_t res
);
  import tcfp_pkg::*;

  logic             in_v_r;
  logic [7:0]       byte_r;
  logic             cs_r;

  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [1:0]        fbc_r, fbc_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  tot_r, tot_nxt;
  logic              isstr_r, isstr_nxt;
  logic              err_r, err_nxt;

  logic [PH_W-1:0]   ph;
  logic [1:0]        fbc;
  logic [WORD_W-1:0] word, word_c;
  logic [LEN_W-1:0]  rem, rem_dec;
  logic [CNT_W-1:0]  cur, cur_inc, tot;
  logic              isstr, err, last;
  logic              proc, has;

  assign proc          = in_v_r && !out_stall;
  assign in_chan.ready = !in_v_r || proc;
  assign step.load       = proc;
  assign step.has_result = has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.data_byte;
      cs_r   <= in_chan.connection_start;
    end
  end

  // connection start clears the parser before the byte is consumed
  always_comb begin
    ph    = cs_r ? PH_NAME_LEN : phase_r;
    fbc   = cs_r ? 2'd0 : fbc_r;
    word  = cs_r ? '0 : word_r;
    rem   = cs_r ? '0 : rem_r;
    cur   = cs_r ? '0 : cur_r;
    tot   = cs_r ? '0 : tot_r;
    isstr = cs_r ? 1'b0 : isstr_r;
    err   = cs_r ? 1'b0 : err_r;
  end

  assign word_c  = (fbc == 2'd0) ? WORD_W'(byte_r)
                                 : (word | (WORD_W'(byte_r) << {fbc, 3'b000}));
  assign last    = (fbc == 2'd3);
  assign rem_dec = rem - LEN_W'(1);
  assign cur_inc = cur + CNT_W'(1);

  always_comb begin
    phase_nxt = ph;
    fbc_nxt   = fbc;
    word_nxt  = word;
    rem_nxt   = rem;
    cur_nxt   = cur;
    tot_nxt   = tot;
    isstr_nxt = isstr;
    err_nxt   = err;
    has       = 1'b0;
    res       = '0;
    if (!err) begin
      unique case (ph)
        PH_NAME_LEN: begin
          word_nxt = word_c;
          fbc_nxt  = fbc + 2'd1;
          if (last) begin
            if (word_c > WORD_W'(caps.str_cap)) begin
              err_nxt        = 1'b1;
              has            = 1'b1;
              res.event_kind = EV_ERROR;
              res.error_code = ERR_LENGTH;
            end else begin
              rem_nxt   = word_c[LEN_W-1:0];
              phase_nxt = (word_c != '0) ? PH_NAME : PH_COUNT;
            end
          end
        end
        PH_NAME: begin
          has              = 1'b1;
          res.event_kind   = EV_NAME_BYTE;
          res.payload_byte = byte_r;
          rem_nxt          = rem_dec;
          if (rem_dec == '0) begin
            res.string_end = 1'b1;
            phase_nxt      = PH_COUNT;
          end
        end
        PH_COUNT: begin
          word_nxt = word_c;
          fbc_nxt  = fbc + 2'd1;
          if (last) begin
            has = 1'b1;
            if (word_c > WORD_W'(caps.cnt_cap)) begin
              err_nxt        = 1'b1;
              res.event_kind = EV_ERROR;
              res.error_code = ERR_COUNT;
            end else begin
              tot_nxt             = word_c[CNT_W-1:0];
              cur_nxt             = '0;
              res.event_kind      = EV_COUNT;
              res.parameter_total = word_c[CNT_W-1:0];
              if (word_c[CNT_W-1:0] == '0) begin
                res.command_done = 1'b1;
                phase_nxt        = PH_NAME_LEN;
              end else begin
                phase_nxt = PH_TYPE;
              end
            end
          end
        end
        PH_TYPE: begin
          isstr_nxt = (byte_r != 8'd0);
          fbc_nxt   = 2'd0;
          phase_nxt = PH_VALUE;
        end
        PH_VALUE: begin
          word_nxt = word_c;
          fbc_nxt  = fbc + 2'd1;
          if (last) begin
            has = 1'b1;
            if (isstr && (word_c > WORD_W'(caps.str_cap))) begin
              err_nxt        = 1'b1;
              res.event_kind = EV_ERROR;
              res.error_code = ERR_LENGTH;
            end else begin
              res.event_kind          = EV_HEAD;
              res.parameter_index     = cur[IDX_W-1:0];
              res.parameter_is_string = isstr;
              res.parameter_value     = word_c;
              if (isstr && (word_c != '0)) begin
                rem_nxt   = word_c[LEN_W-1:0];
                phase_nxt = PH_STRING;
              end else if (cur_inc >= tot) begin
                res.command_done = 1'b1;
                cur_nxt          = '0;
                phase_nxt        = PH_NAME_LEN;
              end else begin
                cur_nxt   = cur_inc;
                phase_nxt = PH_TYPE;
              end
            end
          end
        end
        PH_STRING: begin
          has                     = 1'b1;
          res.event_kind          = EV_STR_BYTE;
          res.payload_byte        = byte_r;
          res.parameter_index     = cur[IDX_W-1:0];
          res.parameter_is_string = 1'b1;
          rem_nxt                 = rem_dec;
          if (rem_dec == '0) begin
            res.string_end = 1'b1;
            // end of parameter, and of the command after the last one
            if (cur_inc >= tot) begin
              res.command_done = 1'b1;
              cur_nxt          = '0;
              phase_nxt        = PH_NAME_LEN;
            end else begin
              cur_nxt   = cur_inc;
              phase_nxt = PH_TYPE;
            end
          end
        end
        default: begin
          phase_nxt = PH_NAME_LEN;
          fbc_nxt   = 2'd0;
          word_nxt  = '0;
          rem_nxt   = '0;
          cur_nxt   = '0;
          tot_nxt   = '0;
          isstr_nxt = 1'b0;
          err_nxt   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NAME_LEN;
      fbc_r   <= 2'd0;
      word_r  <= '0;
      rem_r   <= '0;
      cur_r   <= '0;
      tot_r   <= '0;
      isstr_r <= 1'b0;
      err_r   <= 1'b0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      word_r  <= word_nxt;
      rem_r   <= rem_nxt;
      cur_r   <= cur_nxt;
      tot_r   <= tot_nxt;
      isstr_r <= isstr_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/tcfp_out_reg.sv
// Result register that drives the output channel.
`default_nettype none
module tcfp_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tcfp_pkg::step_t   step,
  input  wire tcfp_pkg::result_t res,
  output logic               out_stall,
  tcfp_out_if.source         out_chan
);
  import tcfp_pkg::*;

  logic    out_v_r;
  result_t res_r;

  assign out_stall = out_v_r && !out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step.load) begin
      out_v_r <= step.has_result;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.load && step.has_result) begin
      res_r <= res;
    end
  end

  assign out_chan.valid               = out_v_r;
  assign out_chan.event_kind          = res_r.event_kind;
  assign out_chan.payload_byte        = res_r.payload_byte;
  assign out_chan.parameter_index     = res_r.parameter_index;
  assign out_chan.parameter_is_string = res_r.parameter_is_string;
  assign out_chan.parameter_value     = res_r.parameter_value;
  assign out_chan.parameter_total     = res_r.parameter_total;
  assign out_chan.error_code          = res_r.error_code;
  assign out_chan.string_end          = res_r.string_end;
  assign out_chan.command_done        = res_r.command_done;

endmodule
`default_nettype wire

FILE: src/tagged_command_frame_parser_unit.sv
// Top level of the tagged command frame parser.
//
// Takes one stream byte per clock while the result side keeps ready high and
// gives at most one result per byte: name bytes, the parameter count,
// parameter heads, string bytes and a single error result, with string_end
// and command_done flags. A byte is captured in an input register, the parse
// state is stepped by the logic after it and the result lands in the output
// register; the parse state update made for each byte sets the sustained rate
// of one byte per cycle. Bytes that give no result (length and count words
// before their last byte, type bytes, anything while an error is latched)
// leave no gap. Setting connection_start on a byte clears the parser and the
// error before that byte.
// The user must write limit registers over the configuration channel only
// while the parser is idle; the block itself does not enforce this. A length
// or count above the smaller of the register and the built-in limit raises
// the error.
`default_nettype none
module tagged_command_frame_parser_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcfp_in_if.sink     in_chan,
  tcfp_out_if.source  out_chan,
  tcfp_cfg_if.sink    cfg_chan
);
  import tcfp_pkg::*;

  caps_t   caps;
  step_t   step;
  result_t res;
  logic    out_stall;

  tcfp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .caps     (caps)
  );

  tcfp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .caps      (caps),
    .out_stall (out_stall),
    .step      (step),
    .res       (res)
  );

  tcfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res       (res),
    .out_stall (out_stall),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire
